@@ src/sarq_pkg.sv @@
// Shared types and constants for the stop-and-wait ARQ sender.
package sarq_pkg;

   // Request codes carried in the request transaction.
   localparam logic [2:0] REQ_START   = 3'd0;
   localparam logic [2:0] REQ_FAILED  = 3'd1;
   localparam logic [2:0] REQ_SHORT   = 3'd2;
   localparam logic [2:0] REQ_TIMEOUT = 3'd3;
   localparam logic [2:0] REQ_ACK     = 3'd4;

   // Action codes carried in the response transaction.
   localparam logic [1:0] ACT_TRANSMIT = 2'd0;
   localparam logic [1:0] ACT_DONE     = 2'd1;
   localparam logic [1:0] ACT_ABORT    = 2'd2;
   localparam logic [1:0] ACT_IGNORED  = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_ERROR_THRESHOLD = 1'b0;
   localparam logic CSR_MAX_TIMEOUTS    = 1'b1;

   // Damaged frame shaping: longest chunk that loses a single byte, largest cut.
   localparam int ShortChunkMax = 10;
   localparam int CutMax        = 10;

   typedef logic       csr_index_type;
   typedef logic [7:0] csr_data_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [23:0] file_length;
      logic [15:0] ack_length;
      logic        ack_seq;
      logic [6:0]  draw;
      logic [3:0]  cut;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [24:0] offset;
      logic [8:0]  payload_len;
      logic        seq_bit;
      logic [8:0]  frame_bytes;
      logic [31:0] sends_total;
      logic [31:0] errors_total;
   } rsp_payload_type;

endpackage

@@ src/sarq_ifs.sv @@
// Valid/ready channel interfaces for the request and response transactions.
interface sarq_req_if;
   import sarq_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sarq_rsp_if;
   import sarq_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/stop_and_wait_arq_sender.sv @@
// Sender side of an alternating-bit stop-and-wait ARQ, one response per request.
//
// Each request transaction is handled as it is accepted: the control state
// (phase, offsets, chunk length, sequence bit and counters) and the response
// register are updated at the same clock edge, so one request is accepted
// every cycle as long as the response register is empty or being drained.
// A start request opens a transfer of file_length + 1 payload bytes, cut into
// chunks of at most MAX_CHUNK bytes; later requests report the fate of the
// last frame (ack, timeout, short send, send failure). Every request answers
// with exactly one response: transmit, done, aborted or ignored. The two
// configuration registers are written via the csr_ port only while idle: a user rule, not enforced.
module stop_and_wait_arq_sender #(
   parameter int MAX_CHUNK    = 500,
   parameter int HEADER_BYTES = 4,
   parameter int LENGTH_BITS  = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   sarq_req_if.sink                req_chan,
   sarq_rsp_if.source              rsp_chan,
   input  logic                    csr_we,
   input  sarq_pkg::csr_index_type csr_index,
   input  sarq_pkg::csr_data_type  csr_wdata
);
   import sarq_pkg::*;

   localparam int FLEN_BITS = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
   localparam int OFF_BITS  = FLEN_BITS + 1;
   localparam int CL_BITS   = $clog2(MAX_CHUNK + 1);
   localparam int CMP_BITS  = (OFF_BITS > CL_BITS) ? OFF_BITS : CL_BITS;

   localparam logic PH_IDLE = 1'b0;
   localparam logic PH_WAIT = 1'b1;

   // Configuration registers.
   logic [6:0] error_threshold_ff;
   logic [7:0] max_timeouts_ff;

   // Transfer state.
   logic                phase_ff, phase_in;
   logic [OFF_BITS-1:0] next_offset_ff, next_offset_in;
   logic [OFF_BITS-1:0] payload_total_ff, payload_total_in;
   logic [CL_BITS-1:0]  chunk_len_ff, chunk_len_in;
   logic                seq_state_ff, seq_state_in;
   logic [7:0]          timeout_run_ff, timeout_run_in;
   logic [31:0]         send_count_ff, send_count_in;
   logic [31:0]         error_count_ff, error_count_in;

   // Response register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Working signals.
   req_payload_type     req;
   logic                accept;
   logic                do_tx;
   logic [1:0]          action;
   logic [OFF_BITS-1:0] out_offset;
   logic [OFF_BITS-1:0] adv_offset;
   logic [OFF_BITS-1:0] rest;
   logic [OFF_BITS-1:0] total_start;
   logic [CL_BITS-1:0]  rest_chunk;
   logic [CL_BITS-1:0]  first_chunk;
   logic [7:0]          run_inc;
   logic [7:0]          timeout_lim;
   logic [31:0]         err_inc;
   logic [31:0]         send_base;
   logic [3:0]          cut_clamped;
   logic [8:0]          frame_dec;
   logic [8:0]          frame_len;
   logic                bad_ack;

   assign req    = req_chan.data;
   assign accept = req_chan.valid && req_chan.ready;

   // The response register frees up when it is empty or taken this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Chunk sizing for a new transfer and for the chunk after a good ack.
   assign total_start = OFF_BITS'(req.file_length[FLEN_BITS-1:0]) + OFF_BITS'(1);
   assign adv_offset  = next_offset_ff + OFF_BITS'(chunk_len_ff);
   assign rest        = payload_total_ff - adv_offset;
   assign first_chunk = (CMP_BITS'(total_start) <= CMP_BITS'(MAX_CHUNK)) ?
                        CL_BITS'(total_start) : CL_BITS'(MAX_CHUNK);
   assign rest_chunk  = (CMP_BITS'(rest) <= CMP_BITS'(MAX_CHUNK)) ?
                        CL_BITS'(rest) : CL_BITS'(MAX_CHUNK);

   // Saturating increments and the timeout limit.
   assign run_inc     = (timeout_run_ff == 8'hFF) ? timeout_run_ff : timeout_run_ff + 8'd1;
   assign err_inc     = (error_count_ff == 32'hFFFF_FFFF) ? error_count_ff :
                        error_count_ff + 32'd1;
   assign timeout_lim = (max_timeouts_ff == 8'd0) ? 8'd1 : max_timeouts_ff;
   assign bad_ack     = (req.ack_length != 16'(chunk_len_ff)) ||
                        (req.ack_seq == seq_state_ff);

   // Next-state and response decode for the request being accepted.
   always_comb begin
      phase_in         = phase_ff;
      next_offset_in   = next_offset_ff;
      payload_total_in = payload_total_ff;
      chunk_len_in     = chunk_len_ff;
      seq_state_in     = seq_state_ff;
      timeout_run_in   = timeout_run_ff;
      error_count_in   = error_count_ff;
      send_base        = send_count_ff;
      do_tx            = 1'b0;
      action           = ACT_IGNORED;
      out_offset       = next_offset_ff;

      if (phase_ff == PH_IDLE) begin
         if (req.req_type == REQ_START) begin
            payload_total_in = total_start;
            next_offset_in   = '0;
            out_offset       = '0;
            chunk_len_in     = first_chunk;
            seq_state_in     = 1'b1;
            timeout_run_in   = '0;
            send_base        = '0;
            error_count_in   = '0;
            phase_in         = PH_WAIT;
            do_tx            = 1'b1;
         end
      end else begin
         unique case (req.req_type)
            REQ_FAILED: begin
               phase_in = PH_IDLE;
               action   = ACT_ABORT;
            end
            REQ_SHORT: begin
               do_tx = 1'b1;
            end
            REQ_TIMEOUT: begin
               error_count_in = err_inc;
               timeout_run_in = run_inc;
               if (run_inc >= timeout_lim) begin
                  phase_in = PH_IDLE;
                  action   = ACT_ABORT;
               end else begin
                  do_tx = 1'b1;
               end
            end
            REQ_ACK: begin
               if (bad_ack) begin
                  error_count_in = err_inc;
                  do_tx          = 1'b1;
               end else begin
                  timeout_run_in = '0;
                  next_offset_in = adv_offset;
                  out_offset     = adv_offset;
                  if (adv_offset >= payload_total_ff) begin
                     phase_in = PH_IDLE;
                     action   = ACT_DONE;
                  end else begin
                     chunk_len_in = rest_chunk;
                     seq_state_in = !seq_state_ff;
                     do_tx        = 1'b1;
                  end
               end
            end
            default: begin
               action = ACT_IGNORED;
            end
         endcase
      end

      if (do_tx) begin
         action = ACT_TRANSMIT;
      end
   end

   // Frame length on the wire, shortened when the draw injects damage.
   always_comb begin
      if (req.cut == 4'd0) begin
         cut_clamped = 4'd1;
      end else if (req.cut > 4'(CutMax)) begin
         cut_clamped = 4'(CutMax);
      end else begin
         cut_clamped = req.cut;
      end

      frame_dec = '0;
      if (req.draw <= error_threshold_ff) begin
         if (chunk_len_in > CL_BITS'(ShortChunkMax)) begin
            frame_dec = 9'(cut_clamped);
         end else if (chunk_len_in != '0) begin
            frame_dec = 9'd1;
         end
      end
      frame_len = 9'(chunk_len_in) + 9'(HEADER_BYTES) - frame_dec;
   end

   // Send counter and the response fields.
   always_comb begin
      send_count_in = send_base;
      if (do_tx && (send_base != 32'hFFFF_FFFF)) begin
         send_count_in = send_base + 32'd1;
      end

      rsp_data_in.action       = action;
      rsp_data_in.offset       = 25'(out_offset);
      rsp_data_in.payload_len  = 9'(chunk_len_in);
      rsp_data_in.seq_bit      = seq_state_in;
      rsp_data_in.frame_bytes  = do_tx ? frame_len : 9'd0;
      rsp_data_in.sends_total  = send_count_in;
      rsp_data_in.errors_total = error_count_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         error_threshold_ff <= 7'd0;
         max_timeouts_ff    <= 8'd4;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ERROR_THRESHOLD: error_threshold_ff <= csr_wdata[6:0];
            CSR_MAX_TIMEOUTS:    max_timeouts_ff    <= csr_wdata;
            default:             max_timeouts_ff    <= max_timeouts_ff;
         endcase
      end
   end

   // Transfer state, updated once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         next_offset_ff   <= '0;
         payload_total_ff <= '0;
         chunk_len_ff     <= '0;
         seq_state_ff     <= 1'b0;
         timeout_run_ff   <= '0;
         send_count_ff    <= '0;
         error_count_ff   <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         next_offset_ff   <= next_offset_in;
         payload_total_ff <= payload_total_in;
         chunk_len_ff     <= chunk_len_in;
         seq_state_ff     <= seq_state_in;
         timeout_run_ff   <= timeout_run_in;
         send_count_ff    <= send_count_in;
         error_count_ff   <= error_count_in;
      end
   end

   // Response register: valid flag under reset, payload loaded on accept.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
